[sv/csg_pkg.sv]
// Shared types, codes and constants of the circular scroll gesture unit.
// No dependencies; every other file of the block imports this package.
package csg_pkg;

   // Input opcodes
   localparam logic [2:0] OP_BUTTON    = 3'd0;
   localparam logic [2:0] OP_ABS_X     = 3'd1;
   localparam logic [2:0] OP_ABS_Y     = 3'd2;
   localparam logic [2:0] OP_ABS_OTHER = 3'd3;
   localparam logic [2:0] OP_OTHER     = 3'd4;

   // Register indexes of the write port
   localparam logic [2:0] REG_CENTER_X    = 3'd0;
   localparam logic [2:0] REG_CENTER_Y    = 3'd1;
   localparam logic [2:0] REG_RIM_RADIUS  = 3'd2;
   localparam logic [2:0] REG_VOLUME_STEP = 3'd3;
   localparam logic [2:0] REG_PAGE_STEP   = 3'd4;
   localparam logic [2:0] REG_ZOOM_STEP   = 3'd5;

   // Register widths and reset values
   localparam int CSR_DATA_BITS     = 17;
   localparam int STEP_BITS         = 17;
   localparam int RESET_CENTER      = 1024;
   localparam int RESET_RIM_RADIUS  = 896;
   localparam int RESET_VOLUME_STEP = 5461;
   localparam int RESET_PAGE_STEP   = 10923;
   localparam int RESET_ZOOM_STEP   = 65536;

   // Arctangent table: 2^32 is a full turn
   localparam int ATAN_IDX_BITS = 5;
   localparam int ANGLE_FRAC    = 32;

   // Command that the front end hands to the back end
   typedef enum logic [2:0] {
      CMD_RELEASE,
      CMD_PASS,
      CMD_SET_X,
      CMD_SET_Y,
      CMD_AXIS
   } csg_cmd_type;

   typedef struct packed {
      csg_cmd_type cmd;
      logic        fn_layer;
   } csg_ctl_type;

   typedef enum logic [2:0] {
      GEST_NONE      = 3'd0,
      GEST_ZOOM_IN   = 3'd1,
      GEST_ZOOM_OUT  = 3'd2,
      GEST_VOL_UP    = 3'd3,
      GEST_VOL_DOWN  = 3'd4,
      GEST_PAGE_BACK = 3'd5,
      GEST_PAGE_FWD  = 3'd6
   } csg_gesture_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_R,
      ST_COMPARE,
      ST_CORDIC,
      ST_ACCUM,
      ST_THRESH,
      ST_RESULT
   } csg_state_type;

   // atan(2^-i) in 2^32-per-turn units
   function automatic logic [31:0] csg_atan(input logic [ATAN_IDX_BITS-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'h2000_0000;
         5'd1:    val = 32'h12E4_051E;
         5'd2:    val = 32'h09FB_385B;
         5'd3:    val = 32'h0511_11D4;
         5'd4:    val = 32'h028B_0D43;
         5'd5:    val = 32'h0145_D7E1;
         5'd6:    val = 32'h00A2_F61E;
         5'd7:    val = 32'h0051_7C55;
         5'd8:    val = 32'h0028_BE53;
         5'd9:    val = 32'h0014_5F2F;
         5'd10:   val = 32'h000A_2F98;
         5'd11:   val = 32'h0005_17CC;
         5'd12:   val = 32'h0002_8BE6;
         5'd13:   val = 32'h0001_45F3;
         5'd14:   val = 32'h0000_A2FA;
         5'd15:   val = 32'h0000_517D;
         5'd16:   val = 32'h0000_28BE;
         5'd17:   val = 32'h0000_145F;
         5'd18:   val = 32'h0000_0A30;
         5'd19:   val = 32'h0000_0518;
         5'd20:   val = 32'h0000_028C;
         5'd21:   val = 32'h0000_0146;
         5'd22:   val = 32'h0000_00A3;
         5'd23:   val = 32'h0000_0051;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

[sv/circular_scroll_gesture_unit.sv]
// Button and non-axis events go from the queue straight to the result state; axis events
// pass delta, squaring and rim compare; rim events then run the iterative CORDIC,
// the accumulate and, but for a first point, the threshold state. The back end takes a
// new event once the last leaves the result state; a two-entry queue buffers meanwhile.
// Reset (synchronous): registers to their defaults, gesture state cleared, queue empty.
module circular_scroll_gesture_unit #(
   parameter int COORD_BITS   = 12,
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_opcode,
   input  logic [COORD_BITS-1:0]              req_value,
   input  logic                               req_fn_active,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_gesture,
   output logic                               rsp_consumed,
   input  logic                               csr_we,
   input  logic [2:0]                         csr_index,
   input  logic [csg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import csg_pkg::*;

   logic [COORD_BITS-1:0]  center_x_ff, center_x_in;
   logic [COORD_BITS-1:0]  center_y_ff, center_y_in;
   logic [COORD_BITS-1:0]  rim_radius_ff, rim_radius_in;
   logic [STEP_BITS-1:0]   volume_step_ff, volume_step_in;
   logic [STEP_BITS-1:0]   page_step_ff, page_step_in;
   logic [STEP_BITS-1:0]   zoom_step_ff, zoom_step_in;
   logic                   q_valid;
   logic                   q_ready;
   csg_ctl_type            q_ctl;
   logic [COORD_BITS-1:0]  q_value;

   // Decode register writes
   always_comb begin
      center_x_in    = center_x_ff;
      center_y_in    = center_y_ff;
      rim_radius_in  = rim_radius_ff;
      volume_step_in = volume_step_ff;
      page_step_in   = page_step_ff;
      zoom_step_in   = zoom_step_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CENTER_X:    center_x_in    = csr_wdata[COORD_BITS-1:0];
            REG_CENTER_Y:    center_y_in    = csr_wdata[COORD_BITS-1:0];
            REG_RIM_RADIUS:  rim_radius_in  = csr_wdata[COORD_BITS-1:0];
            REG_VOLUME_STEP: volume_step_in = csr_wdata[STEP_BITS-1:0];
            REG_PAGE_STEP:   page_step_in   = csr_wdata[STEP_BITS-1:0];
            REG_ZOOM_STEP:   zoom_step_in   = csr_wdata[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= COORD_BITS'(RESET_CENTER);
         center_y_ff    <= COORD_BITS'(RESET_CENTER);
         rim_radius_ff  <= COORD_BITS'(RESET_RIM_RADIUS);
         volume_step_ff <= STEP_BITS'(RESET_VOLUME_STEP);
         page_step_ff   <= STEP_BITS'(RESET_PAGE_STEP);
         zoom_step_ff   <= STEP_BITS'(RESET_ZOOM_STEP);
      end else begin
         center_x_ff    <= center_x_in;
         center_y_ff    <= center_y_in;
         rim_radius_ff  <= rim_radius_in;
         volume_step_ff <= volume_step_in;
         page_step_ff   <= page_step_in;
         zoom_step_ff   <= zoom_step_in;
      end
   end

   // Accept and classify
   csg_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .req_fn_active (req_fn_active),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_ctl         (q_ctl),
      .q_value       (q_value)
   );

   // Angle, rotation sum and gesture decode
   csg_back #(
      .COORD_BITS   (COORD_BITS),
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_ctl        (q_ctl),
      .q_value      (q_value),
      .center_x     (center_x_ff),
      .center_y     (center_y_ff),
      .rim_radius   (rim_radius_ff),
      .volume_step  (volume_step_ff),
      .page_step    (page_step_ff),
      .zoom_step    (zoom_step_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gesture  (rsp_gesture),
      .rsp_consumed (rsp_consumed)
   );

endmodule

[sv/csg_front.sv]
// Front end: accepts touchpad events, classifies them and queues them.
// Depends on csg_pkg for the opcode codes and the command struct.
module csg_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_opcode,
   input  logic [COORD_BITS-1:0]  req_value,
   input  logic                   req_fn_active,
   output logic                   q_valid,
   input  logic                   q_ready,
   output csg_pkg::csg_ctl_type   q_ctl,
   output logic [COORD_BITS-1:0]  q_value
);
   import csg_pkg::*;

   localparam int DEPTH = 2;

   csg_ctl_type            ctl_mem [DEPTH];
   logic [COORD_BITS-1:0]  value_mem [DEPTH];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   csg_ctl_type            ctl_new;
   logic                   push;
   logic                   pop;

   // Classify the event
   always_comb begin
      ctl_new.fn_layer = req_fn_active;
      case (req_opcode)
         OP_BUTTON:    ctl_new.cmd = (req_value == '0) ? CMD_RELEASE : CMD_PASS;
         OP_ABS_X:     ctl_new.cmd = CMD_SET_X;
         OP_ABS_Y:     ctl_new.cmd = CMD_SET_Y;
         OP_ABS_OTHER: ctl_new.cmd = CMD_AXIS;
         default:      ctl_new.cmd = CMD_PASS;
      endcase
   end

   // Queue control
   assign req_ready = (count_ff != 2'(DEPTH));
   assign q_valid   = (count_ff != 2'd0);
   assign push      = req_valid & req_ready;
   assign pop       = q_valid & q_ready;
   assign q_ctl     = ctl_mem[rd_ptr_ff];
   assign q_value   = value_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified item
   always_ff @(posedge clock) begin
      if (push) begin
         ctl_mem[wr_ptr_ff]   <= ctl_new;
         value_mem[wr_ptr_ff] <= req_value;
      end
   end

endmodule

[sv/csg_back.sv]
// Back end: rim test, iterative CORDIC angle, rotation sum and gesture decode.
// Depends on csg_pkg for the command, gesture and state types and the atan table.
module csg_back #(
   parameter int COORD_BITS   = 12,
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_ready,
   input  csg_pkg::csg_ctl_type            q_ctl,
   input  logic [COORD_BITS-1:0]           q_value,
   input  logic [COORD_BITS-1:0]           center_x,
   input  logic [COORD_BITS-1:0]           center_y,
   input  logic [COORD_BITS-1:0]           rim_radius,
   input  logic [csg_pkg::STEP_BITS-1:0]   volume_step,
   input  logic [csg_pkg::STEP_BITS-1:0]   page_step,
   input  logic [csg_pkg::STEP_BITS-1:0]   zoom_step,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_gesture,
   output logic                            rsp_consumed
);
   import csg_pkg::*;

   localparam int DW   = COORD_BITS + 1;
   localparam int SQW  = 2 * COORD_BITS;
   localparam int XW   = COORD_BITS + 12;
   localparam int IW   = $clog2(CORDIC_STEPS);
   localparam int SB   = ANGLE_BITS + 4;
   localparam int DLW  = ANGLE_BITS + 2;
   localparam int LS   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
   localparam int RS   = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
   localparam int TW   = ((SB + LS > STEP_BITS + 1 + RS) ? SB + LS : STEP_BITS + 1 + RS) + 1;
   localparam logic [IW-1:0]  ITER_LAST = IW'(CORDIC_STEPS - 1);
   localparam logic [31:0]    ROUND     = 32'(1) << (ANGLE_FRAC - 1 - ANGLE_BITS);
   localparam logic [31:0]    HALF_TURN = 32'h8000_0000;
   localparam logic signed [DLW-1:0] D_HALF = DLW'(1) << (ANGLE_BITS - 1);
   localparam logic signed [DLW-1:0] D_FULL = DLW'(1) << ANGLE_BITS;
   localparam logic signed [SB-1:0]  SUM_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0]  SUM_MIN = {1'b1, {(SB-1){1'b0}}};

   csg_state_type                 state_ff, state_in;
   logic [COORD_BITS-1:0]         pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]         pos_y_ff, pos_y_in;
   logic [ANGLE_BITS-1:0]         prev_angle_ff, prev_angle_in;
   logic signed [SB-1:0]          sum_ff, sum_in;
   logic                          first_touch_ff, first_touch_in;
   logic                          fn_ff, fn_in;
   logic signed [DW-1:0]          dx_ff, dx_in;
   logic signed [DW-1:0]          dy_ff, dy_in;
   logic [SQW:0]                  acc_ff, acc_in;
   logic [SQW-1:0]                rr_ff, rr_in;
   logic signed [XW-1:0]          x_ff, x_in;
   logic signed [XW-1:0]          y_ff, y_in;
   logic [31:0]                   z_ff, z_in;
   logic [IW-1:0]                 iter_ff, iter_in;
   logic signed [SB-1:0]          pend_sum_ff, pend_sum_in;
   csg_gesture_type               gest_ff, gest_in;
   logic                          cons_ff, cons_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   csg_gesture_type               rsp_gesture_ff, rsp_gesture_in;
   logic                          rsp_consumed_ff, rsp_consumed_in;

   logic [DW-1:0]                 mag_x_w;
   logic [DW-1:0]                 mag_y_w;
   logic [COORD_BITS-1:0]         mul_a;
   logic [SQW-1:0]                prod;
   logic                          below_rim;
   logic                          pop;
   logic                          out_free;
   logic signed [XW-1:0]          x_ext;
   logic signed [XW-1:0]          y_ext;
   logic signed [XW-1:0]          xs;
   logic signed [XW-1:0]          ys;
   logic [31:0]                   atan_val;
   logic [31:0]                   z_round;
   logic [ANGLE_BITS-1:0]         cur_angle;
   logic signed [DLW-1:0]         d_raw;
   logic signed [DLW-1:0]         d_wrap;
   logic signed [SB:0]            sum_wide;
   logic signed [SB-1:0]          sum_sat;
   logic [STEP_BITS-1:0]          step_sel;
   logic [STEP_BITS-1:0]          step_eff;
   logic signed [TW-1:0]          lhs;
   logic signed [TW-1:0]          rhs;
   logic                          hit_pos;
   logic                          hit_neg;
   csg_gesture_type               gest_hit;

   // Handshake helpers
   assign q_ready  = (state_ff == ST_IDLE);
   assign pop      = q_valid & q_ready;
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Shared squarer: |dx|, |dy|, then the rim radius
   assign mag_x_w = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
   assign mag_y_w = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);

   always_comb begin
      case (state_ff)
         ST_SQ_X: mul_a = mag_x_w[COORD_BITS-1:0];
         ST_SQ_Y: mul_a = mag_y_w[COORD_BITS-1:0];
         default: mul_a = rim_radius;
      endcase
   end

   assign prod      = mul_a * mul_a;
   assign below_rim = (acc_ff < {1'b0, rr_ff});

   // CORDIC rotation step
   assign x_ext    = XW'(dx_ff);
   assign y_ext    = XW'(dy_ff);
   assign xs       = x_ff >>> iter_ff;
   assign ys       = y_ff >>> iter_ff;
   assign atan_val = csg_atan(ATAN_IDX_BITS'(iter_ff));

   // Round the angle, wrap the change and saturate the sum
   assign z_round   = z_ff + ROUND;
   assign cur_angle = z_round[31 -: ANGLE_BITS];
   assign d_raw     = $signed({2'b00, cur_angle}) - $signed({2'b00, prev_angle_ff});

   always_comb begin
      if (d_raw > D_HALF) begin
         d_wrap = d_raw - D_FULL;
      end else if (d_raw < -D_HALF) begin
         d_wrap = d_raw + D_FULL;
      end else begin
         d_wrap = d_raw;
      end
   end

   assign sum_wide = (SB+1)'(sum_ff) + (SB+1)'(d_wrap);

   always_comb begin
      if (sum_wide[SB] != sum_wide[SB-1]) begin
         sum_sat = sum_wide[SB] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SB-1:0];
      end
   end

   // Threshold compare by cross-scaling
   always_comb begin
      if (fn_ff) begin
         step_sel = zoom_step;
      end else if (!prev_angle_ff[ANGLE_BITS-1]) begin
         step_sel = volume_step;
      end else begin
         step_sel = page_step;
      end
   end

   assign step_eff = (step_sel == '0) ? STEP_BITS'(1) : step_sel;
   assign lhs      = TW'(pend_sum_ff) <<< LS;
   assign rhs      = $signed(TW'(step_eff) << RS);
   assign hit_pos  = (lhs >= rhs);
   assign hit_neg  = (lhs <= -rhs);

   always_comb begin
      gest_hit = GEST_NONE;
      if (fn_ff) begin
         if (hit_pos) begin
            gest_hit = GEST_ZOOM_IN;
         end else if (hit_neg) begin
            gest_hit = GEST_ZOOM_OUT;
         end
      end else if (!prev_angle_ff[ANGLE_BITS-1]) begin
         if (hit_pos) begin
            gest_hit = GEST_VOL_UP;
         end else if (hit_neg) begin
            gest_hit = GEST_VOL_DOWN;
         end
      end else begin
         if (hit_pos) begin
            gest_hit = GEST_PAGE_BACK;
         end else if (hit_neg) begin
            gest_hit = GEST_PAGE_FWD;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_ctl.cmd inside {CMD_SET_X, CMD_SET_Y, CMD_AXIS}) begin
                  state_in = ST_DELTA;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_DELTA:   state_in = ST_SQ_X;
         ST_SQ_X:    state_in = ST_SQ_Y;
         ST_SQ_Y:    state_in = ST_SQ_R;
         ST_SQ_R:    state_in = ST_COMPARE;
         ST_COMPARE: state_in = below_rim ? ST_RESULT : ST_CORDIC;
         ST_CORDIC: begin
            if (iter_ff == ITER_LAST) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM:   state_in = first_touch_ff ? ST_RESULT : ST_THRESH;
         ST_THRESH:  state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and gesture state
   always_comb begin
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      prev_angle_in  = prev_angle_ff;
      sum_in         = sum_ff;
      first_touch_in = first_touch_ff;
      fn_in          = fn_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      acc_in         = acc_ff;
      rr_in          = rr_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      iter_in        = iter_ff;
      pend_sum_in    = pend_sum_ff;
      gest_in        = gest_ff;
      cons_in        = cons_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               fn_in   = q_ctl.fn_layer;
               gest_in = GEST_NONE;
               cons_in = 1'b0;
               case (q_ctl.cmd)
                  CMD_RELEASE: begin
                     first_touch_in = 1'b1;
                     sum_in         = '0;
                  end
                  CMD_SET_X: pos_x_in = q_value;
                  CMD_SET_Y: pos_y_in = q_value;
                  default: ;
               endcase
            end
         end
         ST_DELTA: begin
            dx_in = $signed({1'b0, pos_x_ff}) - $signed({1'b0, center_x});
            dy_in = $signed({1'b0, pos_y_ff}) - $signed({1'b0, center_y});
         end
         ST_SQ_X: acc_in = {1'b0, prod};
         ST_SQ_Y: acc_in = acc_ff + {1'b0, prod};
         ST_SQ_R: rr_in  = prod;
         ST_COMPARE: begin
            if (below_rim) begin
               first_touch_in = 1'b1;
               sum_in         = '0;
            end else begin
               // Turn points left of the center by half a turn
               if (dx_ff[DW-1]) begin
                  x_in = (-x_ext) <<< 8;
                  y_in = (-y_ext) <<< 8;
                  z_in = HALF_TURN;
               end else begin
                  x_in = x_ext <<< 8;
                  y_in = y_ext <<< 8;
                  z_in = '0;
               end
               iter_in = '0;
            end
         end
         ST_CORDIC: begin
            if (!y_ff[XW-1] && y_ff != '0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_val;
            end else if (y_ff[XW-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_val;
            end
            iter_in = iter_ff + IW'(1);
         end
         ST_ACCUM: begin
            prev_angle_in = cur_angle;
            if (first_touch_ff) begin
               first_touch_in = 1'b0;
            end else begin
               pend_sum_in = sum_sat;
            end
         end
         ST_THRESH: begin
            gest_in = gest_hit;
            cons_in = 1'b1;
            sum_in  = (gest_hit != GEST_NONE) ? '0 : pend_sum_ff;
         end
         default: ;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_gesture_in  = rsp_gesture_ff;
      rsp_consumed_in = rsp_consumed_ff;
      if (state_ff == ST_RESULT && out_free) begin
         rsp_valid_in    = 1'b1;
         rsp_gesture_in  = gest_ff;
         rsp_consumed_in = cons_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gesture  = rsp_gesture_ff;
   assign rsp_consumed = rsp_consumed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         prev_angle_ff  <= '0;
         sum_ff         <= '0;
         first_touch_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         prev_angle_ff  <= prev_angle_in;
         sum_ff         <= sum_in;
         first_touch_ff <= first_touch_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fn_ff           <= fn_in;
      dx_ff           <= dx_in;
      dy_ff           <= dy_in;
      acc_ff          <= acc_in;
      rr_ff           <= rr_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      z_ff            <= z_in;
      iter_ff         <= iter_in;
      pend_sum_ff     <= pend_sum_in;
      gest_ff         <= gest_in;
      cons_ff         <= cons_in;
      rsp_gesture_ff  <= rsp_gesture_in;
      rsp_consumed_ff <= rsp_consumed_in;
   end

   // A re-armed gesture always starts from an empty sum
   a_armed_sum_zero: assert property (@(posedge clock) disable iff (reset)
      first_touch_ff |-> (sum_ff == '0))
      else $error("rotation sum not cleared while first touch is armed");

   // Every popped item leaves idle
   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff != ST_IDLE))
      else $error("back end stayed idle after taking an item");

   // The last CORDIC step hands over to the accumulate step
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC && iter_ff == ITER_LAST) |=> (state_ff == ST_ACCUM))
      else $error("CORDIC did not finish after its last step");

   // A finished item lands in the output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && out_free) |=> rsp_valid_ff)
      else $error("result not loaded into the output register");

   // Only a processed rim event can carry a gesture
   a_gesture_consumed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_gesture_ff != GEST_NONE) |-> rsp_consumed_ff)
      else $error("gesture reported on an event that was not consumed");

endmodule
